@@ sv/wpd_pkg.sv @@
package wpd_pkg;

  localparam int MAX_CHANNELS_DEF = 8;

  // canonical header layout, offsets of the last byte of each field
  localparam logic [5:0] HDR_LEN      = 6'd44;
  localparam logic [5:0] OFF_CHANNELS = 6'd23;
  localparam logic [5:0] OFF_RATE     = 6'd27;
  localparam logic [5:0] OFF_BITS     = 6'd35;
  localparam logic [5:0] OFF_DSIZE    = 6'd43;

  // quotient of (data length * 8) has 35 bits
  localparam int          DIV_STEPS = 35;
  localparam logic [5:0]  DIV_LAST  = 6'(DIV_STEPS - 1);

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [2:0] NB_ONE = 3'd1;
  localparam logic [2:0] NB_TWO = 3'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } wpd_state_t;

  typedef struct packed {
    logic accept_en;
    logic take;
    logic div_init;
    logic div_step;
    logic hdr_emit;
  } wpd_cmd_t;

  typedef struct packed {
    logic hdr_end;
    logic div_last;
    logic out_free;
  } wpd_status_t;

endpackage

@@ sv/wpd_ctrl.sv @@
module wpd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  wpd_pkg::wpd_status_t status,
  output wpd_pkg::wpd_cmd_t    cmd
);
  import wpd_pkg::*;

  wpd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept_en = status.out_free;
        cmd.take      = status.out_free && in_tvalid;
        cmd.div_init  = cmd.take && status.hdr_end;
        if (cmd.div_init) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.hdr_emit = status.out_free;
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/wpd_datapath.sv @@
module wpd_datapath #(
  parameter int MAX_CHANNELS = wpd_pkg::MAX_CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           data_byte,
  input  logic                 start_of_file,
  input  wpd_pkg::wpd_cmd_t    cmd,
  output wpd_pkg::wpd_status_t status,
  input  logic                 out_tready,
  output logic                 out_valid,
  output logic                 out_kind,
  output logic                 out_last,
  output logic [103:0]         out_data
);
  import wpd_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // parse state
  logic [5:0]            off_r;
  logic [31:0]           fa_r;
  logic [15:0]           ch_r;
  logic [15:0]           bits_r;
  logic [31:0]           rate_r;
  logic [31:0]           frames_left_r;
  logic [1:0]            bis_r;
  logic [CH_W-1:0]       chc_r;
  logic                  active_r;

  // divider
  logic [34:0]           quo_r;
  logic [31:0]           rem_r;
  logic [31:0]           divisor_r;
  logic [5:0]            div_cnt_r;

  // output register
  logic                  out_valid_r;
  logic                  out_kind_r;
  logic                  out_last_r;
  logic signed [31:0]    out_sample_r;
  logic [2:0]            out_chan_r;
  logic [31:0]           out_rate_r;
  logic [31:0]           out_frames_r;
  logic                  out_fmt_ok_r;

  logic [5:0]            off_eff;
  logic [31:0]           fa_eff;
  logic [31:0]           fa_nxt;
  logic [2:0]            nbytes;
  logic                  need_more;
  logic                  sample_done;
  logic                  frame_end;
  logic [31:0]           sample_val;
  logic [15:0]           chc_ext;
  logic [32:0]           rem_sh;
  logic                  rem_ge;
  logic [31:0]           frames_calc;
  logic                  fmt_ok;

  assign off_eff = start_of_file ? 6'd0 : off_r;
  assign fa_eff  = start_of_file ? 32'd0 : fa_r;
  assign fa_nxt  = {data_byte, fa_eff[31:8]};

  assign nbytes      = bits_r[5:3];
  assign need_more   = (3'(bis_r) + 3'd1) < nbytes;
  assign sample_done = (off_eff == HDR_LEN) && active_r && !need_more;
  assign chc_ext     = 16'(chc_r);
  assign frame_end   = (chc_ext + 16'd1) >= ch_r;

  always_comb begin
    case (nbytes)
      // 8-bit pcm is offset binary
      NB_ONE:  sample_val = {{24{~fa_nxt[31]}}, ~fa_nxt[31], fa_nxt[30:24]};
      NB_TWO:  sample_val = {{16{fa_nxt[31]}}, fa_nxt[31:16]};
      default: sample_val = fa_nxt;
    endcase
  end

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[34]};
  assign rem_ge = rem_sh >= {1'b0, divisor_r};

  always_comb begin
    if (divisor_r == 32'd0) begin
      frames_calc = 32'd0;
    end else if (quo_r[34:32] != 3'd0) begin
      frames_calc = 32'hFFFF_FFFF;
    end else begin
      frames_calc = quo_r[31:0];
    end
  end

  assign fmt_ok = (ch_r >= 16'd1) && (ch_r <= 16'(MAX_CHANNELS)) &&
                  ((bits_r == 16'd8) || (bits_r == 16'd16) || (bits_r == 16'd32));

  assign status.hdr_end  = (off_eff == OFF_DSIZE);
  assign status.div_last = (div_cnt_r == DIV_LAST);
  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r         <= '0;
      fa_r          <= '0;
      ch_r          <= '0;
      bits_r        <= '0;
      rate_r        <= '0;
      frames_left_r <= '0;
      bis_r         <= '0;
      chc_r         <= '0;
      active_r      <= 1'b0;
      div_cnt_r     <= '0;
    end else begin
      if (cmd.take) begin
        fa_r <= fa_nxt;
        if (start_of_file) begin
          ch_r          <= '0;
          bits_r        <= '0;
          rate_r        <= '0;
          frames_left_r <= '0;
          bis_r         <= '0;
          chc_r         <= '0;
          active_r      <= 1'b0;
        end
        if (off_eff < HDR_LEN) begin
          off_r <= off_eff + 6'd1;
          case (off_eff)
            OFF_CHANNELS: ch_r   <= fa_nxt[31:16];
            OFF_RATE:     rate_r <= fa_nxt;
            OFF_BITS:     bits_r <= fa_nxt[31:16];
            default: ;
          endcase
        end else if (active_r) begin
          if (need_more) begin
            bis_r <= bis_r + 2'd1;
          end else begin
            bis_r <= '0;
            if (frame_end) begin
              chc_r         <= '0;
              frames_left_r <= frames_left_r - 32'd1;
              if (frames_left_r == 32'd1) begin
                active_r <= 1'b0;
              end
            end else begin
              chc_r <= chc_r + CH_W'(1);
            end
          end
        end
      end
      if (cmd.div_init) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 6'd1;
      end
      if (cmd.hdr_emit) begin
        frames_left_r <= frames_calc;
        bis_r         <= '0;
        chc_r         <= '0;
        active_r      <= fmt_ok && (frames_calc != 32'd0);
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r     <= {fa_nxt, 3'b000};
      rem_r     <= '0;
      divisor_r <= {16'd0, ch_r} * {16'd0, bits_r};
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[33:0], rem_ge};
      rem_r <= rem_ge ? 32'(rem_sh - {1'b0, divisor_r}) : rem_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.take && sample_done) || cmd.hdr_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && sample_done) begin
      out_kind_r   <= KIND_SAMPLE;
      out_sample_r <= sample_val;
      out_chan_r   <= chc_ext[2:0];
      out_rate_r   <= '0;
      out_frames_r <= '0;
      out_fmt_ok_r <= 1'b1;
      out_last_r   <= frame_end && (frames_left_r == 32'd1);
    end else if (cmd.hdr_emit) begin
      out_kind_r   <= KIND_HEADER;
      out_sample_r <= '0;
      out_chan_r   <= '0;
      out_rate_r   <= rate_r;
      out_frames_r <= frames_calc;
      out_fmt_ok_r <= fmt_ok;
      out_last_r   <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;
  assign out_data  = {4'd0, out_fmt_ok_r, out_frames_r, out_rate_r, out_chan_r, out_sample_r};

endmodule

@@ sv/wav_pcm_stream_decoder.sv @@
// Streaming WAV decoder. Bytes of a file with the canonical 44-byte PCM header
// enter one per transaction; in_tuser marks offset 0 and restarts the parse at
// any point. Header and data bytes are taken one per cycle while the output
// register is free. After header byte 43 the input stalls for the bit-serial
// divide that yields the frame count floor(8*data length/(channels*bits)) and,
// once the output register is free, for the header result (kind 0). Then each
// complete sample of 8, 16 or 32 bits gives one result (kind 1) per channel per
// frame, tlast on the final one. A single output register sits between the
// sides, so a stalled out_tready holds the input only while a result is pending.
module wav_pcm_stream_decoder #(
  parameter int MAX_CHANNELS = wpd_pkg::MAX_CHANNELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] start_of_file
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] sample_value, [34:32] channel, [66:35] rate_hz,
  // [98:67] frame_count, [99] format_ok, [103:100] zero
  output logic [103:0] out_tdata,
  output logic         out_tuser,  // [0] kind
  output logic         out_tlast
);
  import wpd_pkg::*;

  wpd_cmd_t    cmd;
  wpd_status_t status;

  wpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .status    (status),
    .cmd       (cmd)
  );

  wpd_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .data_byte     (in_tdata),
    .start_of_file (in_tuser),
    .cmd           (cmd),
    .status        (status),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_kind      (out_tuser),
    .out_last      (out_tlast),
    .out_data      (out_tdata)
  );

  assign in_tready = cmd.accept_en;

endmodule
